// ===== src/spq_pkg.sv =====
// Shared types, codes and sizes for the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 8;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_LOOK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRIO_W-1:0]         item_priority;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] front_value;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        entry_count;
  } rsp_t;

  typedef struct packed {
    logic                      valid;
    logic [PRIO_W-1:0]         prio;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t op;
    entry_t   item;
  } cell_cmd_t;

endpackage

// ===== src/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: cell chain, entry counter and result register.
// A result beat is registered and appears in the cycle after its request beat is accepted.
// One request per cycle; the whole chain of cells shifts at once for an insert or a
// remove, so the only limit is the result register draining downstream.
// Reset clears the entry count, the valid bit of every cell and the result valid;
// stored values and priorities are not cleared and are never read while unoccupied.
module sorted_priority_queue_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp
);

  localparam int N = spq_pkg::CAPACITY;

  // Occupancy counter; it always equals the number of valid cells.
  logic [spq_pkg::COUNT_W-1:0] count;
  logic [spq_pkg::COUNT_W-1:0] count_next;

  logic req_accept;
  logic is_full;
  logic is_empty;

  spq_pkg::cell_cmd_t cmd;
  spq_pkg::rsp_t      rsp_next;
  logic               rsp_valid_next;

  spq_pkg::entry_t entry      [N];
  spq_pkg::entry_t entry_next [N];
  logic            ahead      [N];
  logic [N-1:0]    valid_vec;

  // The result register is the only stage, so a new request is taken whenever that
  // register is empty or its beat is leaving in this cycle.
  assign req_stall  = rsp_valid && rsp_stall;
  assign req_accept = req_valid && !req_stall;

  assign is_full  = (count == spq_pkg::COUNT_W'(N));
  assign is_empty = (count == '0);

  // Decode the request into one command that every cell sees. Refused inserts and
  // removes on an empty queue leave the chain as it is.
  always_comb begin
    cmd.op         = spq_pkg::OP_HOLD;
    cmd.item.valid = 1'b1;
    cmd.item.prio  = req.item_priority;
    cmd.item.value = req.item_value;
    count_next     = count;
    rsp_next.status = spq_pkg::ST_OK;
    case (req.func)
      spq_pkg::FN_INSERT: begin
        if (is_full) begin
          rsp_next.status = spq_pkg::ST_FULL;
        end else begin
          cmd.op     = spq_pkg::OP_INSERT;
          count_next = count + spq_pkg::COUNT_W'(1);
        end
      end
      spq_pkg::FN_REMOVE: begin
        if (is_empty) begin
          rsp_next.status = spq_pkg::ST_EMPTY;
        end else begin
          cmd.op     = spq_pkg::OP_REMOVE;
          count_next = count - spq_pkg::COUNT_W'(1);
        end
      end
      default: begin
        // A look, and the unused code, only report the front.
        if (is_empty) begin
          rsp_next.status = spq_pkg::ST_EMPTY;
        end
      end
    endcase
    if (!req_accept) begin
      cmd.op     = spq_pkg::OP_HOLD;
      count_next = count;
    end
    // The front after this request is whatever the first cell is about to hold.
    rsp_next.front_value = entry_next[0].valid ? entry_next[0].value
                                               : -32'sd1;
    rsp_next.entry_count = count_next;
  end

  // The chain: each cell sees its left neighbor for an insert shift and its right
  // neighbor for a remove shift. The first cell has no left neighbor ahead of the
  // new item, and the last cell pulls in an empty slot on a remove.
  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      spq_pkg::entry_t left_e;
      spq_pkg::entry_t right_e;
      logic            left_a;

      if (i == 0) begin : g_first
        assign left_e = cmd.item;
        assign left_a = 1'b0;
      end else begin : g_mid
        assign left_e = entry[i-1];
        assign left_a = ahead[i-1];
      end

      if (i == N - 1) begin : g_last
        always_comb begin
          right_e       = entry[i];
          right_e.valid = 1'b0;
        end
      end else begin : g_inner
        assign right_e = entry[i+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .left_entry  (left_e),
        .left_ahead  (left_a),
        .right_entry (right_e),
        .entry       (entry[i]),
        .entry_next  (entry_next[i]),
        .ahead       (ahead[i])
      );

      assign valid_vec[i] = entry[i].valid;
    end
  endgenerate

  // A result beat is loaded on every accepted request and held while stalled.
  always_comb begin
    if (req_accept) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_stall) begin
      rsp_valid_next = rsp_valid;
    end else begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      rsp <= rsp_next;
    end
  end

  // Occupied cells always form an unbroken run starting at the front of the chain.
  logic [N:0] valid_run;
  assign valid_run = {1'b0, valid_vec} + (N+1)'(1);

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("entry count differs from number of occupied cells");

  a_cells_contiguous: assert property (@(posedge clk) disable iff (rst)
    $onehot(valid_run))
    else $error("occupied cells are not contiguous from the front");

  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == spq_pkg::ST_FULL) |->
      rsp.entry_count == spq_pkg::COUNT_W'(N))
    else $error("insert refused while the queue was not full");

  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    req_accept && (count_next == '0) |=> rsp.front_value == -32'sd1)
    else $error("empty queue reported a front value");

  generate
    for (i = 0; i < N - 1; i++) begin : g_order_chk
      a_sorted: assert property (@(posedge clk) disable iff (rst)
        entry[i+1].valid |->
          (entry[i].prio > entry[i+1].prio) ||
          ((entry[i].prio == entry[i+1].prio) &&
           !(entry[i].value < entry[i+1].value)))
        else $error("adjacent cells out of order");
    end
  endgenerate

endmodule

// ===== src/spq_cell.sv =====
// One storage cell of the sorted chain: holds an entry, shifts with its neighbors.
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::cell_cmd_t cmd,
  input  spq_pkg::entry_t    left_entry,
  input  logic               left_ahead,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output spq_pkg::entry_t    entry_next,
  output logic               ahead
);

  spq_pkg::entry_t q;

  // The new item belongs ahead of this cell when the cell is empty, holds a lower
  // priority, or holds an equal priority with a value that is not greater.
  always_comb begin
    ahead = !q.valid || (q.prio < cmd.item.prio) ||
            ((q.prio == cmd.item.prio) && !(q.value > cmd.item.value));
  end

  always_comb begin
    entry_next = q;
    case (cmd.op)
      spq_pkg::OP_INSERT: begin
        if (ahead) begin
          entry_next = left_ahead ? left_entry : cmd.item;
        end
      end
      spq_pkg::OP_REMOVE: begin
        entry_next = right_entry;
      end
      default: begin
        entry_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q <= entry_next;
    end
  end

  assign entry = q;

endmodule

// ===== verif/sorted_priority_queue_top_tb.sv =====
// Self-checking testbench for the sorted priority queue top level.
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;

  // The func field has one spare code; the block treats it as a look.
  localparam logic [1:0] FN_SPARE = 2'd3;

  localparam logic signed [spq_pkg::VALUE_W-1:0] VALUE_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [spq_pkg::VALUE_W-1:0] VALUE_MIN   = 32'sh8000_0000;
  localparam logic signed [spq_pkg::VALUE_W-1:0] EMPTY_FRONT = -1;
  localparam logic [spq_pkg::PRIO_W-1:0]         PRIO_MAX    = 8'hFF;

  // Length of the one long receiver hold-off, in clock cycles.
  localparam int LONG_HOLD = 80;
  // Extra cycles allowed after the last expected beat.
  localparam int SETTLE_CYCLES = 4;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  spq_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  spq_pkg::rsp_t rsp;

  sorted_priority_queue_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the sorted store. Only the first queue_depth slots mean anything.
  logic signed [spq_pkg::VALUE_W-1:0] shadow_value [spq_pkg::CAPACITY];
  logic [spq_pkg::PRIO_W-1:0]         shadow_prio  [spq_pkg::CAPACITY];
  int                                 queue_depth = 0;

  // Result beats predicted for accepted requests, oldest first.
  spq_pkg::rsp_t awaited_results [$];
  int            fail_count = 0;

  // Idling controls shared between the test tasks and the receiver side process.
  bit feed_gaps_on      = 1'b0;
  bit result_stalls_on  = 1'b0;
  bit long_hold_pending = 1'b0;
  int stall_cycles_left = 0;

  // Applies one request to the shadow store and returns the result it must produce.
  // A new entry goes ahead of the first entry with lower priority, or with equal
  // priority and a value that is not greater, so ties land in front.
  function automatic spq_pkg::rsp_t predict_queue_result(spq_pkg::req_t r);
    spq_pkg::rsp_t                      res;
    logic signed [spq_pkg::VALUE_W-1:0] val;
    int                                 slot;
    int                                 i;
    val        = $signed(r.item_value);
    res.status = spq_pkg::ST_OK;
    if (r.func == spq_pkg::FN_INSERT) begin
      if (queue_depth >= spq_pkg::CAPACITY) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        slot = 0;
        while (slot < queue_depth &&
               (shadow_prio[slot] > r.item_priority ||
                (shadow_prio[slot] == r.item_priority && shadow_value[slot] > val)))
          slot++;
        for (i = queue_depth; i > slot; i--) begin
          shadow_value[i] = shadow_value[i-1];
          shadow_prio[i]  = shadow_prio[i-1];
        end
        shadow_value[slot] = val;
        shadow_prio[slot]  = r.item_priority;
        queue_depth++;
      end
    end else if (r.func == spq_pkg::FN_REMOVE) begin
      if (queue_depth == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        for (i = 0; i + 1 < queue_depth; i++) begin
          shadow_value[i] = shadow_value[i+1];
          shadow_prio[i]  = shadow_prio[i+1];
        end
        queue_depth--;
      end
    end else begin
      // Look, and the spare code that behaves as a look.
      if (queue_depth == 0) res.status = spq_pkg::ST_EMPTY;
    end
    res.front_value = (queue_depth == 0) ? EMPTY_FRONT : shadow_value[0];
    res.entry_count = spq_pkg::COUNT_W'(queue_depth);
    return res;
  endfunction

  function automatic spq_pkg::req_t make_req(logic [1:0] fn,
                                             logic signed [spq_pkg::VALUE_W-1:0] val,
                                             logic [spq_pkg::PRIO_W-1:0] prio);
    spq_pkg::req_t r;
    r.func          = fn;
    r.item_value    = val;
    r.item_priority = prio;
    return r;
  endfunction

  // Values lean toward the extremes and a narrow band around zero so that ties
  // on priority also meet ties and near-ties on value.
  function automatic logic signed [spq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      2, 3:    return spq_pkg::VALUE_W'($urandom_range(0, 7) - 4);
      default: return spq_pkg::VALUE_W'($urandom());
    endcase
  endfunction

  function automatic logic [spq_pkg::PRIO_W-1:0] pick_prio();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return PRIO_MAX;
      2, 3:    return spq_pkg::PRIO_W'($urandom_range(0, 3));
      default: return spq_pkg::PRIO_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Random request; insert_pct sets how hard the mix pushes toward a full store.
  // Payload fields are random on every operation, since remove and look ignore them.
  function automatic spq_pkg::req_t pick_request(int insert_pct);
    int            roll;
    spq_pkg::req_t r;
    roll            = $urandom_range(0, 99);
    r.item_value    = pick_value();
    r.item_priority = pick_prio();
    if (roll < insert_pct)  r.func = spq_pkg::FN_INSERT;
    else if (roll < 90)     r.func = spq_pkg::FN_REMOVE;
    else if (roll < 97)     r.func = spq_pkg::FN_LOOK;
    else                    r.func = FN_SPARE;
    return r;
  endfunction

  // Offers one request beat and returns in the time step where it was accepted,
  // after an optional idle burst. Valid is left high when no burst follows, so
  // back-to-back calls keep the channel busy without lowering it in between.
  task automatic offer_request(input spq_pkg::req_t r);
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    awaited_results.push_back(predict_queue_result(r));
    if (feed_gaps_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Sender pauses with valid low until every predicted beat has come back.
  task automatic wait_until_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic test_empty_queue();
    offer_request(make_req(spq_pkg::FN_LOOK, VALUE_MAX, PRIO_MAX));
    offer_request(make_req(spq_pkg::FN_REMOVE, VALUE_MIN, '0));
    offer_request(make_req(FN_SPARE, 32'sd12345, 8'd77));
  endtask

  // Directed order checks: priority extremes, value extremes and exact ties,
  // then removes down to empty so the last remove leaves nothing behind.
  task automatic test_ordering_rules();
    int n;
    offer_request(make_req(spq_pkg::FN_INSERT, 32'sd0, 8'd5));
    offer_request(make_req(spq_pkg::FN_INSERT, VALUE_MAX, 8'd5));
    offer_request(make_req(spq_pkg::FN_INSERT, VALUE_MIN, 8'd5));
    offer_request(make_req(spq_pkg::FN_INSERT, -32'sd1, 8'd5));
    offer_request(make_req(spq_pkg::FN_INSERT, 32'sd0, 8'd5));
    offer_request(make_req(spq_pkg::FN_INSERT, VALUE_MIN, PRIO_MAX));
    offer_request(make_req(spq_pkg::FN_INSERT, VALUE_MAX, 8'd0));
    offer_request(make_req(spq_pkg::FN_LOOK, '0, '0));
    offer_request(make_req(FN_SPARE, -32'sd1, PRIO_MAX));
    for (n = 0; n < 7; n++)
      offer_request(make_req(spq_pkg::FN_REMOVE, VALUE_MAX, PRIO_MAX));
    offer_request(make_req(spq_pkg::FN_LOOK, VALUE_MIN, PRIO_MAX));
  endtask

  // Fills the store to capacity, tries two inserts that must be refused, then
  // empties it and removes once more past empty.
  task automatic test_full_store();
    int n;
    for (n = 0; n < spq_pkg::CAPACITY + 2; n++)
      offer_request(make_req(spq_pkg::FN_INSERT, pick_value(), pick_prio()));
    offer_request(make_req(spq_pkg::FN_LOOK, pick_value(), pick_prio()));
    for (n = 0; n < spq_pkg::CAPACITY + 1; n++)
      offer_request(make_req(spq_pkg::FN_REMOVE, pick_value(), pick_prio()));
  endtask

  // Bulk random traffic in segments that alternately fill and drain the store,
  // with a sender pause after every few segments.
  task automatic test_random_mix();
    int seg;
    int n;
    for (seg = 0; seg < 16; seg++) begin
      for (n = 0; n < 40; n++) offer_request(pick_request(seg % 2 == 0 ? 75 : 25));
      if (seg % 5 == 4) wait_until_drained();
    end
  endtask

  // The receiver stalls for a long stretch while the sender keeps valid high,
  // so the result register stays full and the block has to stall its input.
  task automatic test_result_backpressure();
    int n;
    bit saved_gaps;
    saved_gaps        = feed_gaps_on;
    feed_gaps_on      = 1'b0;
    long_hold_pending = 1'b1;
    for (n = 0; n < 30; n++) offer_request(pick_request(70));
    feed_gaps_on = saved_gaps;
    wait_until_drained();
  endtask

  task automatic test_sender_pause();
    int n;
    for (n = 0; n < 8; n++) offer_request(pick_request(80));
    wait_until_drained();
    for (n = 0; n < 8; n++) offer_request(pick_request(30));
  endtask

  // Last stretch of the run with no idling on either side.
  task automatic test_steady_stream();
    int n;
    feed_gaps_on     = 1'b0;
    result_stalls_on = 1'b0;
    for (n = 0; n < 100; n++) offer_request(pick_request(n < 50 ? 65 : 35));
  endtask

  // Receiver side: random stall bursts, plus the single long hold-off counted here.
  always @(posedge clk) begin
    if (stall_cycles_left > 0) begin
      stall_cycles_left <= stall_cycles_left - 1;
      rsp_stall         <= 1'b1;
    end else if (long_hold_pending) begin
      long_hold_pending = 1'b0;
      stall_cycles_left <= LONG_HOLD - 1;
      rsp_stall         <= 1'b1;
    end else if (result_stalls_on && $urandom_range(0, 5) == 0) begin
      stall_cycles_left <= $urandom_range(1, 19) - 1;
      rsp_stall         <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Each accepted result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    spq_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: front_value %0d status %0d count %0d",
               $signed(rsp.front_value), rsp.status, rsp.entry_count);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (rsp.front_value !== want.front_value) begin
          $error("front_value: expected %0d, actual %0d",
                 $signed(want.front_value), $signed(rsp.front_value));
          fail_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          fail_count++;
        end
        if (rsp.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, rsp.entry_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    feed_gaps_on     = 1'b1;
    result_stalls_on = 1'b1;

    test_empty_queue();
    test_ordering_rules();
    test_full_store();
    test_random_mix();
    test_result_backpressure();
    test_sender_pause();
    test_steady_stream();

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop if the run does not finish.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_top.sv
verif/sorted_priority_queue_top_tb.sv
